>>> hw/rtl/nrt_pkg.sv
// ----------------------------------------------------------------------------
// nrt_pkg: shared types and codes for the named reading table
// Request and status codes, default sizes, and the command and status groups
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package nrt_pkg;

    localparam int DEF_TABLE_DEPTH = 16;
    localparam int DEF_NAME_CHARS  = 9;

    localparam int NAME_W    = 72;
    localparam int KEY_LO_W  = 64;
    localparam int CHAR_W    = 8;
    localparam int READING_W = 32;
    localparam int REQ_W     = 2;
    localparam int STATUS_W  = 2;

    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd1;
    localparam logic [REQ_W-1:0] REQ_DELETE = 2'd2;
    localparam logic [REQ_W-1:0] REQ_DUMP   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

    typedef struct packed {
        logic                load;
        logic                start_walk;
        logic                step_down;
        logic                step_up;
        logic                start_shift;
        logic                write_down;
        logic                ins_write;
        logic                dec;
        logic                emit;
        logic [STATUS_W-1:0] emit_status;
        logic                emit_data;
        logic                emit_walk_last;
    } nrt_cmd_t;

    typedef struct packed {
        logic cnt_zero;
        logic cnt_full;
        logic rd_ok;
        logic rd_match;
        logic rd_first;
        logic walk_end;
    } nrt_stat_t;

endpackage

>>> hw/rtl/nrt_ctrl.sv
// ----------------------------------------------------------------------------
// nrt_ctrl: request sequencer
// Steps each request through insert, scan, hit/miss, shift and dump phases,
// issues datapath commands and owns the result beat valid flag.
// ----------------------------------------------------------------------------
module nrt_ctrl
    import nrt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [REQ_W-1:0] req_type,
    output logic             out_valid,
    input  logic             out_stall,
    input  nrt_stat_t        stat,
    output nrt_cmd_t         cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_SCAN,
        S_HIT,
        S_MISS,
        S_SHIFT,
        S_DUMP
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   is_del_reg;
    logic   is_del_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd         = '0;
        state_next  = state_reg;
        is_del_next = is_del_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load    = 1'b1;
                    is_del_next = (req_type == REQ_DELETE);
                    case (req_type)
                        REQ_INSERT:
                        begin
                            state_next = S_INS;
                        end
                        REQ_SEARCH, REQ_DELETE:
                        begin
                            cmd.start_walk = 1'b1;
                            state_next     = stat.cnt_zero ? S_MISS : S_SCAN;
                        end
                        default:
                        begin
                            cmd.start_walk = 1'b1;
                            state_next     = stat.cnt_zero ? S_MISS : S_DUMP;
                        end
                    endcase
                end
            end
            S_INS:
            begin
                if (slot_free)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = stat.cnt_full ? ST_FULL : ST_OK;
                    cmd.ins_write   = !stat.cnt_full;
                    state_next      = S_IDLE;
                end
            end
            S_SCAN:
            begin
                if (stat.rd_ok && stat.rd_match)
                begin
                    state_next = S_HIT;
                end
                else if (stat.rd_ok && stat.rd_first)
                begin
                    state_next = S_MISS;
                end
                else
                begin
                    cmd.step_down = 1'b1;
                end
            end
            S_HIT:
            begin
                if (slot_free)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = ST_OK;
                    cmd.emit_data   = 1'b1;
                    if (is_del_reg)
                    begin
                        cmd.start_shift = 1'b1;
                        state_next      = S_SHIFT;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_MISS:
            begin
                if (slot_free)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = ST_NOT_FOUND;
                    state_next      = S_IDLE;
                end
            end
            S_SHIFT:
            begin
                if (!stat.rd_ok && stat.walk_end)
                begin
                    cmd.dec    = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.write_down = stat.rd_ok;
                    cmd.step_up    = 1'b1;
                end
            end
            S_DUMP:
            begin
                if (stat.rd_ok)
                begin
                    if (slot_free)
                    begin
                        cmd.emit           = 1'b1;
                        cmd.emit_status    = ST_OK;
                        cmd.emit_data      = 1'b1;
                        cmd.emit_walk_last = 1'b1;
                        cmd.step_down      = 1'b1;
                    end
                end
                else if (!stat.walk_end)
                begin
                    cmd.step_down = 1'b1;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            is_del_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            is_del_reg    <= is_del_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> hw/rtl/nrt_dp.sv
// ----------------------------------------------------------------------------
// nrt_dp: table datapath
// Entry memory kept oldest first at low addresses, entry count, walk pointer,
// registered read port with match compare, and the result beat registers.
// ----------------------------------------------------------------------------
module nrt_dp
    import nrt_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int NAME_CHARS  = DEF_NAME_CHARS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  nrt_cmd_t             cmd,
    output nrt_stat_t            stat,
    input  logic [KEY_LO_W-1:0]  key_first8,
    input  logic [CHAR_W-1:0]    key_ninth,
    input  logic [READING_W-1:0] reading_bits,
    output logic [STATUS_W-1:0]  status,
    output logic [KEY_LO_W-1:0]  found_first8,
    output logic [CHAR_W-1:0]    found_ninth,
    output logic [READING_W-1:0] found_reading,
    output logic                 last_of_run
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic [NAME_W-1:0]    name_mem [TABLE_DEPTH];
    logic [READING_W-1:0] rdg_mem  [TABLE_DEPTH];

    logic [CW-1:0]        cnt_reg;
    logic [CW-1:0]        cnt_next;
    logic [AW-1:0]        ptr_reg;
    logic [AW-1:0]        ptr_next;
    logic                 end_reg;
    logic                 end_next;
    logic                 rd_ok_reg;
    logic                 rd_ok_next;
    logic [AW-1:0]        rd_addr_reg;
    logic [AW-1:0]        rd_addr_next;
    logic [NAME_W-1:0]    rd_name_reg;
    logic [READING_W-1:0] rd_rdg_reg;
    logic [NAME_W-1:0]    key_reg;
    logic [READING_W-1:0] rdg_reg;
    logic                 rd_take;

    logic [CW-1:0]        cnt_m1;
    logic [CW-1:0]        shift_start;
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [NAME_W-1:0]    mem_wname;
    logic [READING_W-1:0] mem_wrdg;

    function automatic logic [NAME_W-1:0] normalise(input logic [KEY_LO_W-1:0] lo,
                                                    input logic [CHAR_W-1:0] ninth);
        logic [NAME_W-1:0] full;
        logic [NAME_W-1:0] n;
        logic [CHAR_W-1:0] c;
        logic              ended;
        full  = {ninth, lo};
        n     = '0;
        ended = 1'b0;
        for (int i = 0; i < 9; i++)
        begin
            c = full[CHAR_W*i +: CHAR_W];
            if (i >= NAME_CHARS || c == '0)
            begin
                ended = 1'b1;
            end
            if (!ended)
            begin
                n[CHAR_W*i +: CHAR_W] = c;
            end
        end
        return n;
    endfunction

    assign cnt_m1      = cnt_reg - CW'(1);
    assign shift_start = CW'(rd_addr_reg) + CW'(1);

    always_comb
    begin
        stat          = '0;
        stat.cnt_zero = (cnt_reg == '0);
        stat.cnt_full = (cnt_reg == CW'(TABLE_DEPTH));
        stat.rd_ok    = rd_ok_reg;
        stat.rd_match = (rd_name_reg == key_reg);
        stat.rd_first = (rd_addr_reg == '0);
        stat.walk_end = end_reg;
    end

    always_comb
    begin
        cnt_next     = cnt_reg;
        ptr_next     = ptr_reg;
        end_next     = end_reg;
        rd_ok_next   = rd_ok_reg;
        rd_addr_next = rd_addr_reg;
        rd_take      = 1'b0;
        if (cmd.ins_write)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        else if (cmd.dec)
        begin
            cnt_next = cnt_m1;
        end
        if (cmd.start_walk)
        begin
            ptr_next   = cnt_m1[AW-1:0];
            end_next   = 1'b0;
            rd_ok_next = 1'b0;
        end
        else if (cmd.start_shift)
        begin
            ptr_next   = shift_start[AW-1:0];
            end_next   = (shift_start == cnt_reg);
            rd_ok_next = 1'b0;
        end
        else if (cmd.step_down || cmd.step_up)
        begin
            if (end_reg)
            begin
                rd_ok_next = 1'b0;
            end
            else
            begin
                rd_take      = 1'b1;
                rd_ok_next   = 1'b1;
                rd_addr_next = ptr_reg;
                if (cmd.step_down)
                begin
                    if (ptr_reg == '0)
                    begin
                        end_next = 1'b1;
                    end
                    else
                    begin
                        ptr_next = ptr_reg - AW'(1);
                    end
                end
                else
                begin
                    if (CW'(ptr_reg) == cnt_m1)
                    begin
                        end_next = 1'b1;
                    end
                    else
                    begin
                        ptr_next = ptr_reg + AW'(1);
                    end
                end
            end
        end
    end

    always_comb
    begin
        mem_we    = cmd.ins_write || cmd.write_down;
        mem_waddr = cmd.ins_write ? cnt_reg[AW-1:0] : (rd_addr_reg - AW'(1));
        mem_wname = cmd.ins_write ? key_reg : rd_name_reg;
        mem_wrdg  = cmd.ins_write ? rdg_reg : rd_rdg_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            ptr_reg     <= '0;
            end_reg     <= 1'b1;
            rd_ok_reg   <= 1'b0;
            rd_addr_reg <= '0;
        end
        else
        begin
            cnt_reg     <= cnt_next;
            ptr_reg     <= ptr_next;
            end_reg     <= end_next;
            rd_ok_reg   <= rd_ok_next;
            rd_addr_reg <= rd_addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            name_mem[mem_waddr] <= mem_wname;
            rdg_mem[mem_waddr]  <= mem_wrdg;
        end
        if (rd_take)
        begin
            rd_name_reg <= name_mem[ptr_reg];
            rd_rdg_reg  <= rdg_mem[ptr_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg <= normalise(key_first8, key_ninth);
            rdg_reg <= reading_bits;
        end
        if (cmd.emit)
        begin
            status        <= cmd.emit_status;
            found_first8  <= cmd.emit_data ? rd_name_reg[KEY_LO_W-1:0] : '0;
            found_ninth   <= cmd.emit_data ? rd_name_reg[NAME_W-1:KEY_LO_W] : '0;
            found_reading <= cmd.emit_data ? rd_rdg_reg : '0;
            last_of_run   <= cmd.emit_walk_last ? (rd_addr_reg == '0) : 1'b1;
        end
    end

endmodule

>>> hw/rtl/named_reading_table.sv
// ----------------------------------------------------------------------------
// named_reading_table: bounded table of named sensor readings
// Newest-first table without gaps; insert, search, delete of the newest
// match, and dump of all entries.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_stall    req_type key_first8 key_ninth
//                                              reading_bits
//   out      output     out_valid / out_stall  status found_first8 found_ninth
//                                              found_reading last_of_run
//
// One request at a time; the search, delete and dump walks step through the
// entry memory one entry a cycle while the output is open, using the single
// read and write port of the entry memory.
// Reset clears the entry count and walk state; no clearing pass over the memory.
// A stalled result beat holds; the dump walk pauses until it is taken.
// ----------------------------------------------------------------------------
module named_reading_table
    import nrt_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int NAME_CHARS  = DEF_NAME_CHARS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [REQ_W-1:0]     req_type,
    input  logic [KEY_LO_W-1:0]  key_first8,
    input  logic [CHAR_W-1:0]    key_ninth,
    input  logic [READING_W-1:0] reading_bits,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [STATUS_W-1:0]  status,
    output logic [KEY_LO_W-1:0]  found_first8,
    output logic [CHAR_W-1:0]    found_ninth,
    output logic [READING_W-1:0] found_reading,
    output logic                 last_of_run
);

    nrt_cmd_t  cmd;
    nrt_stat_t stat;

    nrt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .req_type  (req_type),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    nrt_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .NAME_CHARS  (NAME_CHARS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .key_first8    (key_first8),
        .key_ninth     (key_ninth),
        .reading_bits  (reading_bits),
        .status        (status),
        .found_first8  (found_first8),
        .found_ninth   (found_ninth),
        .found_reading (found_reading),
        .last_of_run   (last_of_run)
    );

endmodule
